/* hdl/iarf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII radix formatter package
// Shared types, register indexes, radix codes and character constants.
// ----------------------------------------------------------------------------
package iarf_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} ctl_state_t;

	localparam int VALUE_W = 32;
	localparam int CFG_W   = 6;
	localparam int CHAR_W  = 8;
	localparam int PRE_W   = 2;
	localparam int IDX_W   = 2;

	// Radix codes held in the base register.
	localparam logic [1:0] BASE_BIN = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_BASE     = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd1;
	localparam logic [IDX_W-1:0] REG_UNSIGNED = 2'd2;

	localparam logic [1:0]       BASE_RESET     = BASE_DEC;
	localparam logic [CFG_W-1:0] WIDTH_RESET    = 6'd32;
	localparam logic             UNSIGNED_RESET = 1'b0;
	localparam logic [CFG_W-1:0] MIN_WIDTH      = 6'd4;

	localparam logic [CHAR_W-1:0] CH_ZERO        = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ONE         = 8'h31;
	localparam logic [CHAR_W-1:0] CH_B           = 8'h62;
	localparam logic [CHAR_W-1:0] CH_X           = 8'h78;
	localparam logic [CHAR_W-1:0] CH_MINUS       = 8'h2D;
	localparam logic [CHAR_W-1:0] HEX_LETTER_OFS = 8'd55;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic skip_step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] base;
		logic       conv_last;
		logic       skip_done;
		logic       slot_free;
		logic       emit_last;
	} dp_status_t;

endpackage

/* hdl/iarf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter controller
// Sequences load, binary-to-BCD conversion, leading-zero skip and emission.
// ----------------------------------------------------------------------------
module iarf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  iarf_pkg::dp_status_t sts,
	output logic                 in_stall,
	output iarf_pkg::dp_cmd_t    cmd
);
	import iarf_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (sts.base) inside
						BASE_BIN, BASE_HEX: state_d = ST_EMIT;
						BASE_DEC:           state_d = ST_CONV;
						default:            state_d = ST_IDLE;
					endcase
				end
			end
			ST_CONV: begin
				if (sts.conv_last) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (sts.skip_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.slot_free && sts.emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.conv_step = (state_q == ST_CONV);
		cmd.skip_step = (state_q == ST_SKIP) && !sts.skip_done;
		cmd.emit      = (state_q == ST_EMIT) && sts.slot_free;
	end

endmodule

/* hdl/iarf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter datapath
// Configuration registers, value shifter, double-dabble BCD converter and
// the registered character output.
// ----------------------------------------------------------------------------
module iarf_datapath #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [iarf_pkg::IDX_W-1:0]    cfg_index,
	input  logic [iarf_pkg::CFG_W-1:0]    cfg_data,
	input  logic [iarf_pkg::VALUE_W-1:0]  value,
	input  logic                          out_stall,
	input  iarf_pkg::dp_cmd_t             cmd,
	output iarf_pkg::dp_status_t          sts,
	output logic                          out_valid,
	output logic [iarf_pkg::CHAR_W-1:0]   character,
	output logic                          last
);
	import iarf_pkg::*;

	localparam int VW     = (MAX_WIDTH < VALUE_W) ? MAX_WIDTH : VALUE_W;
	// Decimal digits for a VW-bit magnitude: floor(VW * log10(2)) + 1.
	localparam int DIGITS = (VW * 30103) / 100000 + 1;
	localparam int BCD_W  = 4 * DIGITS;
	localparam int IW     = $clog2(VW);
	localparam int CW     = $clog2(VW + 1);

	logic [1:0]       base_q;
	logic [CFG_W-1:0] width_q;
	logic             uns_q;

	logic [VW-1:0]    shreg_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    rem_q;
	logic [PRE_W-1:0] pre_q;

	logic              ovalid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic [CFG_W-1:0]  w_eff;
	logic [CW-1:0]     w_cw;
	logic [VW-1:0]     mask;
	logic [VW-1:0]     val_m;
	logic [IW-1:0]     top_idx;
	logic              neg;
	logic [VW-1:0]     mag;
	logic [BCD_W-1:0]  adj;
	logic [CW-1:0]     rem_m1;
	logic [IW-1:0]     bit_idx;
	logic [3:0]        nib;
	logic [3:0]        dec_digit;
	logic [CHAR_W-1:0] char_d;
	logic              slot_free;
	logic              emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RESET;
			width_q <= WIDTH_RESET;
			uns_q   <= UNSIGNED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE:     base_q  <= cfg_data[1:0];
				REG_WIDTH:    width_q <= cfg_data;
				REG_UNSIGNED: uns_q   <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// Width saturates into 4..VW.
	always_comb begin
		if (width_q < MIN_WIDTH) begin
			w_eff = MIN_WIDTH;
		end else if (width_q > CFG_W'(VW)) begin
			w_eff = CFG_W'(VW);
		end else begin
			w_eff = width_q;
		end
	end

	assign w_cw    = CW'(w_eff);
	assign mask    = ~({VW{1'b1}} << w_eff);
	assign val_m   = value[VW-1:0] & mask;
	assign top_idx = IW'(w_eff - 6'd1);
	assign neg     = !uns_q && val_m[top_idx];
	assign mag     = neg ? ((~val_m + VW'(1)) & mask) : val_m;

	// Shift-and-add-3 correction on every BCD digit before the next shift.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
			                                           : bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shreg_q <= (base_q == BASE_DEC) ? mag : val_m;
			bcd_q   <= '0;
			cnt_q   <= CW'(VW);
			case (base_q)
				BASE_BIN: begin
					pre_q <= 2'd2;
					rem_q <= w_cw;
				end
				BASE_HEX: begin
					pre_q <= 2'd2;
					rem_q <= w_cw >> 2;
				end
				default: begin
					pre_q <= {1'b0, neg};
					rem_q <= CW'(DIGITS);
				end
			endcase
		end else if (cmd.conv_step) begin
			bcd_q   <= {adj[BCD_W-2:0], shreg_q[VW-1]};
			shreg_q <= shreg_q << 1;
			cnt_q   <= cnt_q - CW'(1);
		end else if (cmd.skip_step) begin
			bcd_q <= bcd_q << 4;
			rem_q <= rem_q - CW'(1);
		end else if (cmd.emit) begin
			if (pre_q != '0) begin
				pre_q <= pre_q - PRE_W'(1);
			end else begin
				rem_q <= rem_q - CW'(1);
				bcd_q <= bcd_q << 4;
			end
		end
	end

	assign rem_m1    = rem_q - CW'(1);
	assign bit_idx   = IW'(rem_m1);
	assign nib       = 4'(shreg_q >> {rem_m1, 2'b00});
	assign dec_digit = bcd_q[BCD_W-1 -: 4];

	always_comb begin
		if (pre_q == 2'd2) begin
			char_d = CH_ZERO;
		end else if (pre_q == 2'd1) begin
			case (base_q)
				BASE_BIN: char_d = CH_B;
				BASE_HEX: char_d = CH_X;
				default:  char_d = CH_MINUS;
			endcase
		end else begin
			case (base_q)
				BASE_BIN: char_d = shreg_q[bit_idx] ? CH_ONE : CH_ZERO;
				BASE_HEX: char_d = (nib <= 4'd9) ? ({4'h0, nib} + CH_ZERO)
				                                 : ({4'h0, nib} + HEX_LETTER_OFS);
				default:  char_d = CH_ZERO + {4'h0, dec_digit};
			endcase
		end
	end

	assign slot_free = !ovalid_q || !out_stall;
	assign emit_last = (pre_q == '0) && (rem_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= char_d;
			last_q <= emit_last;
		end
	end

	always_comb begin
		sts.base      = base_q;
		sts.conv_last = (cnt_q == CW'(1));
		sts.skip_done = (dec_digit != 4'd0) || (rem_q == CW'(1));
		sts.slot_free = slot_free;
		sts.emit_last = emit_last;
	end

	assign out_valid = ovalid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

/* hdl/integer_to_ascii_radix_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII radix formatter
// Turns each accepted value into binary, decimal or hexadecimal text, one
// character per output request, with last set on the final character.
// ----------------------------------------------------------------------------
// One value is handled at a time and text leaves at one character per cycle
// when the output is not stalled. Binary at width w gives w + 2 characters
// and hex floor(w/4) + 2. Decimal first runs a double-dabble converter that
// takes one magnitude bit per cycle (MAX_WIDTH bits, capped at 32), then
// drops leading zero digits at one per cycle (up to 9 at 32 bits), then
// emits an optional minus sign and the digits. The input is stalled from
// acceptance until the last character has been loaded into the output
// register. An unused base code consumes a value and produces no text.
module integer_to_ascii_radix_formatter #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [iarf_pkg::IDX_W-1:0]    cfg_index,
	input  logic [iarf_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [iarf_pkg::VALUE_W-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [iarf_pkg::CHAR_W-1:0]   character,
	output logic                          last
);
	import iarf_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t sts;

	iarf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	iarf_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.value     (value),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.character (character),
		.last      (last)
	);

	// Accepting a value in a valid radix leaves the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall &&
		 (sts.base == BASE_BIN || sts.base == BASE_DEC || sts.base == BASE_HEX))
		|=> in_stall)
	else $error("formatter returned to idle right after accepting a value");

	// When idle, a character still waiting at the output must end its text.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall && out_valid) |-> last)
	else $error("idle with a non-final character pending");

endmodule
